>>> src/lwpt_pkg.sv
// ============================================================================
// lwpt_pkg - shared constants and types for the lottery pick tree
// Sizes of the tree, payload widths, opcodes and the divider status bundle.
// ============================================================================
`default_nettype none

package lwpt_pkg;

    // Tree geometry: a perfect binary tree, root at node 1, leaves at
    // nodes NUM_ENTRIES .. 2*NUM_ENTRIES-1 (entry count is a power of two)
    localparam int NUM_ENTRIES = 1024;
    localparam int IDX_W       = $clog2(NUM_ENTRIES);
    localparam int NODE_W      = IDX_W + 1;
    localparam int NODE_DEPTH  = 2 * NUM_ENTRIES;
    localparam int LEVEL_W     = $clog2(IDX_W + 1);

    // Payload widths; SUM_W holds NUM_ENTRIES * (2**TICKET_W - 1) exactly
    localparam int TICKET_W    = 16;
    localparam int SUM_W       = 26;
    localparam int RAND_W      = 31;

    // Step counter width of the modulo unit
    localparam int DIV_CNT_W   = $clog2(RAND_W + 1);

    // Opcodes
    localparam logic OP_SET  = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    // Status of the modulo unit
    typedef struct packed {
        logic busy;
        logic done;
    } lwpt_div_status_t;

endpackage

`default_nettype wire

>>> src/lwpt_mod_div.sv
// ============================================================================
// lwpt_mod_div - restoring modulo unit
// Reduces the random value modulo the ticket total, one dividend bit a cycle.
// ============================================================================
`default_nettype none

module lwpt_mod_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [lwpt_pkg::RAND_W-1:0]   dividend,
    input  wire logic [lwpt_pkg::SUM_W-1:0]    divisor,
    output lwpt_pkg::lwpt_div_status_t         status,
    output logic [lwpt_pkg::SUM_W-1:0]         remainder
);
    import lwpt_pkg::*;

    logic                  active_reg, active_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [RAND_W-1:0]     dvd_reg, dvd_next;
    logic [SUM_W-1:0]      dsr_reg, dsr_next;
    logic [SUM_W-1:0]      rem_reg, rem_next;

    logic [SUM_W:0]        trial;
    logic [SUM_W:0]        diff;
    logic [SUM_W-1:0]      rem_step;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign trial    = {rem_reg, dvd_reg[RAND_W-1]};
    assign diff     = trial - {1'b0, dsr_reg};
    assign rem_step = (trial >= {1'b0, dsr_reg}) ? diff[SUM_W-1:0] : trial[SUM_W-1:0];

    // Next-state logic
    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        dvd_next    = dvd_reg;
        dsr_next    = dsr_reg;
        rem_next    = rem_reg;
        if (start)
        begin
            active_next = 1'b1;
            cnt_next    = DIV_CNT_W'(RAND_W);
            dvd_next    = dividend;
            dsr_next    = divisor;
            rem_next    = '0;
        end
        else if (active_reg)
        begin
            rem_next = rem_step;
            dvd_next = {dvd_reg[RAND_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign status.busy = active_reg;
    assign status.done = done_reg;
    assign remainder   = rem_reg;

endmodule

`default_nettype wire

>>> src/lottery_weighted_pick_tree.sv
// ============================================================================
// lottery_weighted_pick_tree - weighted random picker kept as a sum tree
// Ticket updates walk leaf to root; draws reduce modulo the total and descend.
// ============================================================================
// Usage:
//   Command channel: a transaction is taken at a clock edge with start high
//   and busy low. opcode selects set-tickets (entry_index, tickets) or draw
//   (random_value). Every transaction yields exactly one result, shown for a
//   single cycle with done high: granted, winner_index, ticket_sum.
//   The receiver cannot stall; a result must be captured when done is high.
// Steps (accept edge to done cycle):
//   set: the old leaf count is read and compared; an unchanged count ends
//   there, a changed one writes the leaf, then one read-modify-write of the
//   node memory per tree level, overlapped. draw, empty pool: answered from
//   the idle state; draw: the bit-serial modulo unit (S_MOD), S_WALK_START
//   and one read per tree level. busy stays high for the whole operation (an
//   empty-pool draw never raises it), so items are handled one at a time;
//   the next may be started in the cycle that done is shown.
// Reset:
//   All node sums start at zero. After rst_n releases, a clearing pass
//   writes the 2048-entry node memory, one entry a cycle; busy is high for
//   the whole pass.
// ============================================================================
`default_nettype none

module lottery_weighted_pick_tree (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           opcode,
    input  wire logic [lwpt_pkg::IDX_W-1:0]     entry_index,
    input  wire logic [lwpt_pkg::TICKET_W-1:0]  tickets,
    input  wire logic [lwpt_pkg::RAND_W-1:0]    random_value,
    output logic                                done,
    output logic                                granted,
    output logic [lwpt_pkg::IDX_W-1:0]          winner_index,
    output logic [lwpt_pkg::SUM_W-1:0]          ticket_sum
);
    import lwpt_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR      = 8'b0000_0001,
        S_IDLE       = 8'b0000_0010,
        S_LEAF_RD    = 8'b0000_0100,
        S_LEAF_CHK   = 8'b0000_1000,
        S_UPD        = 8'b0001_0000,
        S_MOD        = 8'b0010_0000,
        S_WALK_START = 8'b0100_0000,
        S_WALK       = 8'b1000_0000
    } state_t;

    // Node on the root-to-leaf path of idx at the given level (root = level 0)
    function automatic logic [NODE_W-1:0] path_node(
        input logic [IDX_W-1:0]   idx,
        input logic [LEVEL_W-1:0] level
    );
        logic [NODE_W-1:0] full;
        full = {1'b1, idx};
        return full >> (LEVEL_W'(IDX_W) - level);
    endfunction

    state_t              state_reg, state_next;
    logic [NODE_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [LEVEL_W-1:0]  level_reg, level_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [TICKET_W-1:0] tickets_reg, tickets_next;
    logic [SUM_W-1:0]    delta_reg, delta_next;
    logic [SUM_W-1:0]    total_reg, total_next;
    logic [NODE_W-1:0]   node_reg, node_next;
    logic [SUM_W-1:0]    r_reg, r_next;
    logic                done_reg, done_next;
    logic                granted_reg, granted_next;
    logic [IDX_W-1:0]    winner_reg, winner_next;
    logic [SUM_W-1:0]    total_out_reg, total_out_next;

    // Node sum memory
    logic [SUM_W-1:0]    node_mem [NODE_DEPTH];
    logic                mem_we;
    logic [NODE_W-1:0]   mem_waddr;
    logic [SUM_W-1:0]    mem_wdata;
    logic [NODE_W-1:0]   mem_raddr;
    logic [SUM_W-1:0]    mem_rdata_reg;

    // Modulo unit
    logic                div_start;
    lwpt_div_status_t    div_status;
    logic [SUM_W-1:0]    div_rem;

    // Datapath helpers
    logic [SUM_W-1:0]    leaf_delta;
    logic [NODE_W-1:0]   node_step;
    logic                go_left;

    lwpt_mod_div u_mod_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (random_value),
        .divisor   (total_reg),
        .status    (div_status),
        .remainder (div_rem)
    );

    // Change of the leaf count; wraps, sums stay exact within SUM_W
    assign leaf_delta = SUM_W'(tickets_reg) - mem_rdata_reg;

    // Descent step: left child when the residue lies in the left sum
    assign go_left   = (r_reg < mem_rdata_reg);
    assign node_step = {node_reg[NODE_W-2:0], ~go_left};

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        level_next     = level_reg;
        idx_next       = idx_reg;
        tickets_next   = tickets_reg;
        delta_next     = delta_reg;
        total_next     = total_reg;
        node_next      = node_reg;
        r_next         = r_reg;
        done_next      = 1'b0;
        granted_next   = granted_reg;
        winner_next    = winner_reg;
        total_out_next = total_out_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_raddr      = '0;
        div_start      = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == NODE_W'(NODE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    case (opcode)
                        OP_SET:
                        begin
                            idx_next     = entry_index;
                            tickets_next = tickets;
                            state_next   = S_LEAF_RD;
                        end
                        OP_DRAW:
                        begin
                            if (total_reg == '0)
                            begin
                                // empty pool: answer at once
                                done_next      = 1'b1;
                                granted_next   = 1'b0;
                                winner_next    = '0;
                                total_out_next = total_reg;
                            end
                            else
                            begin
                                div_start  = 1'b1;
                                state_next = S_MOD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Fetch the old leaf count
            S_LEAF_RD:
            begin
                mem_raddr  = {1'b1, idx_reg};
                state_next = S_LEAF_CHK;
            end

            // Unchanged count: finish; else write the new leaf, start the climb toward the root
            S_LEAF_CHK:
            begin
                if (leaf_delta == '0)
                begin
                    done_next      = 1'b1;
                    granted_next   = 1'b0;
                    winner_next    = '0;
                    total_out_next = total_reg;
                    state_next     = S_IDLE;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = {1'b1, idx_reg};
                    mem_wdata  = SUM_W'(tickets_reg);
                    mem_raddr  = path_node(idx_reg, LEVEL_W'(IDX_W - 1));
                    delta_next = leaf_delta;
                    total_next = total_reg + leaf_delta;
                    level_next = LEVEL_W'(IDX_W - 1);
                    state_next = S_UPD;
                end
            end

            // Write this level while reading the one above; finish at the root
            S_UPD:
            begin
                mem_we    = 1'b1;
                mem_waddr = path_node(idx_reg, level_reg);
                mem_wdata = mem_rdata_reg + delta_reg;
                if (level_reg == '0)
                begin
                    done_next      = 1'b1;
                    granted_next   = 1'b0;
                    winner_next    = '0;
                    total_out_next = total_reg;
                    state_next     = S_IDLE;
                end
                else
                begin
                    mem_raddr  = path_node(idx_reg, level_reg - 1'b1);
                    level_next = level_reg - 1'b1;
                end
            end

            // Wait for the residue
            S_MOD:
            begin
                if (div_status.done && !div_status.busy)
                begin
                    r_next     = div_rem;
                    node_next  = NODE_W'(1);
                    level_next = '0;
                    state_next = S_WALK_START;
                end
            end

            // Read the left child of the root
            S_WALK_START:
            begin
                mem_raddr  = {node_reg[NODE_W-2:0], 1'b0};
                state_next = S_WALK;
            end

            // Compare against the left sum, read the next left child
            S_WALK:
            begin
                if (!go_left)
                begin
                    r_next = r_reg - mem_rdata_reg;
                end
                node_next  = node_step;
                mem_raddr  = {node_step[NODE_W-2:0], 1'b0};
                level_next = level_reg + 1'b1;
                if (level_reg == LEVEL_W'(IDX_W - 1))
                begin
                    done_next      = 1'b1;
                    granted_next   = 1'b1;
                    winner_next    = node_step[IDX_W-1:0];
                    total_out_next = total_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            level_reg   <= '0;
            total_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            level_reg   <= level_next;
            total_reg   <= total_next;
            done_reg    <= done_next;
        end
    end

    // Datapath and result registers
    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        tickets_reg   <= tickets_next;
        delta_reg     <= delta_next;
        node_reg      <= node_next;
        r_reg         <= r_next;
        granted_reg   <= granted_next;
        winner_reg    <= winner_next;
        total_out_reg <= total_out_next;
    end

    // Node memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            node_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= node_mem[mem_raddr];
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign granted      = granted_reg;
    assign winner_index = winner_reg;
    assign ticket_sum   = total_out_reg;

endmodule

`default_nettype wire

>>> src/lwpt_checker.sv
// ============================================================================
// lwpt_checker - port-level checks for the lottery pick tree
// Watches the command and result ports over time; bound to the top level.
// ============================================================================
`default_nettype none

module lwpt_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic                           busy,
    input  wire logic                           opcode,
    input  wire logic                           done,
    input  wire logic                           granted,
    input  wire logic [lwpt_pkg::IDX_W-1:0]     winner_index,
    input  wire logic [lwpt_pkg::SUM_W-1:0]     ticket_sum
);
    import lwpt_pkg::*;

    // A result is shown only once the block is free again
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // No grant means no winner
    a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !granted) |-> (winner_index == '0))
        else $error("winner index set without a grant");

    // A ticket update always occupies the block
    a_set_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && opcode == OP_SET) |=> busy)
        else $error("update transaction did not raise busy");

    // A grant comes only from a non-empty pool
    a_grant_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && granted) |-> (ticket_sum != '0))
        else $error("grant with an empty pool");

endmodule

bind lottery_weighted_pick_tree lwpt_checker u_lwpt_checker (.*);

`default_nettype wire

>>> verif/tb.sv
// ============================================================================
// tb - self-checking testbench for lottery_weighted_pick_tree
// Drives set-tickets and draw transactions over the start/busy command port.
// A sum-tree predictor inside the bench mirrors every accepted transaction.
// Each done strobe is checked field by field against the oldest prediction.
// ============================================================================
`timescale 1ns / 100ps

module tb;
    import lwpt_pkg::*;

    localparam int LEAF_BASE      = NUM_ENTRIES;
    localparam int HOT_ENTRIES    = 32;
    localparam int MISMATCH_SHOWN = 10;
    localparam int GAP_CAP        = 30;
    localparam int DRAIN_CYCLES   = 4000;
    localparam int TAIL_CYCLES    = 64;

    localparam logic [TICKET_W-1:0] TICKETS_MAX = '1;
    localparam logic [RAND_W-1:0]   RAND_MAX    = '1;
    localparam logic [IDX_W-1:0]    LAST_ENTRY  = '1;

    typedef struct packed {
        logic                granted;
        logic [IDX_W-1:0]    winner;
        logic [SUM_W-1:0]    total;
    } pick_result_t;

    // DUT ports
    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                start        = 1'b0;
    logic                opcode       = OP_SET;
    logic [IDX_W-1:0]    entry_index  = '0;
    logic [TICKET_W-1:0] tickets      = '0;
    logic [RAND_W-1:0]   random_value = '0;
    logic                busy;
    logic                done;
    logic                granted;
    logic [IDX_W-1:0]    winner_index;
    logic [SUM_W-1:0]    ticket_sum;

    // Predictor state: per-entry tickets and the sum tree, root at node 1
    logic [TICKET_W-1:0] entry_tickets [NUM_ENTRIES];
    logic [SUM_W-1:0]    subtree_sum   [2 * NUM_ENTRIES];

    pick_result_t expected_picks [$];

    int unsigned mismatch_count  = 0;
    int          sender_idle_pct = 0;
    int unsigned set_count       = 0;
    int unsigned draw_count      = 0;
    int unsigned grant_count     = 0;
    int unsigned empty_count     = 0;

    lottery_weighted_pick_tree DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .entry_index  (entry_index),
        .tickets      (tickets),
        .random_value (random_value),
        .done         (done),
        .granted      (granted),
        .winner_index (winner_index),
        .ticket_sum   (ticket_sum)
    );

    // 4 ns clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // Run limit, far beyond the slowest legal run
    initial
    begin
        #2ms;
        $display("timeout with %0d results outstanding", expected_picks.size());
        $display("[lottery_weighted_pick_tree] ERROR");
        $finish;
    end

    // Apply one transaction to the predictor and return its result
    function automatic pick_result_t predict_pick(input logic op,
                                                  input logic [IDX_W-1:0] idx,
                                                  input logic [TICKET_W-1:0] tk,
                                                  input logic [RAND_W-1:0] rnd);
        pick_result_t      res;
        int unsigned       node;
        logic [RAND_W-1:0] remainder;
        res = '0;
        if (op == OP_SET)
        begin
            // leaf-to-root delta; an unchanged count touches nothing
            if (tk != entry_tickets[idx])
            begin
                for (node = LEAF_BASE + idx; node >= 1; node = node >> 1)
                    subtree_sum[node] = subtree_sum[node] - entry_tickets[idx] + tk;
                entry_tickets[idx] = tk;
            end
        end
        else if (subtree_sum[1] != '0)
        begin
            // descend toward the leaf whose ticket range holds the remainder
            remainder = rnd % subtree_sum[1];
            node = 1;
            while (node < LEAF_BASE)
            begin
                if (remainder < subtree_sum[2 * node])
                    node = 2 * node;
                else
                begin
                    remainder = remainder - subtree_sum[2 * node];
                    node = 2 * node + 1;
                end
            end
            res.granted = 1'b1;
            res.winner  = IDX_W'(node - LEAF_BASE);
        end
        res.total = subtree_sum[1];
        return res;
    endfunction

    task automatic note_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
        mismatch_count++;
        if (mismatch_count <= MISMATCH_SHOWN)
            $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
    endtask

    // Result checker: every done strobe pairs with the oldest prediction
    always @(posedge clk)
    begin : result_check
        pick_result_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (expected_picks.size() == 0)
                note_mismatch("unexpected result", 0, ticket_sum);
            else
            begin
                want = expected_picks.pop_front();
                if (granted !== want.granted)
                    note_mismatch("granted", want.granted, granted);
                if (winner_index !== want.winner)
                    note_mismatch("winner_index", want.winner, winner_index);
                if (ticket_sum !== want.total)
                    note_mismatch("ticket_sum", want.total, ticket_sum);
            end
        end
    end

    // Send one transaction; returns at the edge that accepts it
    task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
                             input logic [TICKET_W-1:0] tk, input logic [RAND_W-1:0] rnd);
        int unsigned  gap;
        pick_result_t res;
        // idle cycles are counted only while the block is ready
        if ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            gap = 0;
            do
            begin
                @(posedge clk);
                if (busy === 1'b0)
                    gap++;
            end
            while (gap == 0 || (gap < GAP_CAP && $urandom_range(99) < sender_idle_pct));
        end
        start        <= 1'b1;
        opcode       <= op;
        entry_index  <= idx;
        tickets      <= tk;
        random_value <= rnd;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        res = predict_pick(op, idx, tk, rnd);
        expected_picks.push_back(res);
        if (op == OP_SET)
            set_count++;
        else
        begin
            draw_count++;
            if (res.granted)
                grant_count++;
            else
                empty_count++;
        end
    endtask

    // Hold off until every prediction has been matched, then let the block settle
    task automatic wait_for_drain();
        int unsigned guard;
        guard = 0;
        start <= 1'b0;
        @(posedge clk);
        while (expected_picks.size() != 0 && guard < DRAIN_CYCLES)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Draws and a retire on a freshly cleared tree
    task automatic test_empty_pool();
        send_item(OP_DRAW, IDX_W'($urandom), TICKET_W'($urandom), RAND_MAX);
        send_item(OP_DRAW, IDX_W'($urandom), TICKET_W'($urandom), '0);
        send_item(OP_SET, 10'd5, '0, RAND_W'($urandom));
    endtask

    // First and last entries, the midpoint split, extreme random values
    task automatic test_edge_entries();
        send_item(OP_SET, '0, 16'd1, RAND_W'($urandom));
        send_item(OP_DRAW, '0, '0, '0);
        send_item(OP_SET, LAST_ENTRY, TICKETS_MAX, RAND_W'($urandom));
        send_item(OP_DRAW, '0, '0, '0);
        send_item(OP_DRAW, '0, '0, 31'd1);
        send_item(OP_DRAW, LAST_ENTRY, TICKETS_MAX, RAND_MAX);
        send_item(OP_SET, 10'd511, 16'd100, RAND_W'($urandom));
        send_item(OP_SET, 10'd512, 16'd200, RAND_W'($urandom));
        send_item(OP_DRAW, '0, '0, 31'd1);
        send_item(OP_DRAW, '0, '0, 31'd101);
    endtask

    // Rewriting a count with its current value
    task automatic test_same_count();
        send_item(OP_SET, LAST_ENTRY, TICKETS_MAX, RAND_MAX);
        send_item(OP_SET, 10'd511, 16'd100, '0);
        send_item(OP_DRAW, '0, '0, 31'd300);
    endtask

    // Retire every populated entry, then draw on the empty pool again
    task automatic test_retire();
        send_item(OP_SET, '0, '0, RAND_W'($urandom));
        send_item(OP_SET, LAST_ENTRY, '0, RAND_W'($urandom));
        send_item(OP_SET, 10'd511, '0, RAND_W'($urandom));
        send_item(OP_SET, 10'd512, '0, RAND_W'($urandom));
        send_item(OP_DRAW, '0, '0, 31'd12345);
    endtask

    // Mixed traffic on a hot set of entries plus scattered ones
    task automatic test_random_traffic(input int idle_pct, input int n_items);
        logic                op;
        logic [IDX_W-1:0]    idx;
        logic [TICKET_W-1:0] tk;
        logic [RAND_W-1:0]   rnd;
        int unsigned         pick;
        int                  i;
        sender_idle_pct = idle_pct;
        for (i = 0; i < n_items; i++)
        begin
            op = ($urandom_range(99) < 45) ? OP_SET : OP_DRAW;

            pick = $urandom_range(99);
            if (pick < 55)
                idx = IDX_W'($urandom_range(HOT_ENTRIES - 1) * 33);
            else if (pick < 62)
                idx = pick[0] ? LAST_ENTRY : '0;
            else
                idx = IDX_W'($urandom);

            pick = $urandom_range(99);
            if (pick < 15)
                tk = '0;
            else if (pick < 25)
                tk = entry_tickets[idx];
            else if (pick < 33)
                tk = TICKETS_MAX;
            else if (pick < 55)
                tk = TICKET_W'($urandom_range(15, 1));
            else
                tk = TICKET_W'($urandom);

            pick = $urandom_range(99);
            if (pick < 20)
                rnd = RAND_W'($urandom_range(255));
            else if (pick < 25)
                rnd = RAND_MAX;
            else if (pick < 28)
                rnd = '0;
            else
                rnd = RAND_W'($urandom);

            // sender holds off once mid-phase until the block is empty
            if (i == n_items / 2)
                wait_for_drain();
            send_item(op, idx, tk, rnd);
        end
    endtask

    // Main sequence
    initial
    begin : main_sequence
        int k;
        for (k = 0; k < NUM_ENTRIES; k++)
            entry_tickets[k] = '0;
        for (k = 0; k < 2 * NUM_ENTRIES; k++)
            subtree_sum[k] = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        sender_idle_pct = 0;
        test_empty_pool();
        test_edge_entries();
        test_same_count();
        test_retire();

        test_random_traffic(18, 310);
        test_random_traffic(73, 310);
        test_random_traffic(0, 310);

        wait_for_drain();
        if (expected_picks.size() != 0)
        begin
            mismatch_count += expected_picks.size();
            $display("%0d expected results never arrived", expected_picks.size());
        end

        $display("covered %0d ticket updates and %0d draws (%0d granted, %0d on an empty pool)",
                 set_count, draw_count, grant_count, empty_count);
        $display("sender idle at 18%%, 73%% and 0%%; %0d mismatches", mismatch_count);
        if (mismatch_count == 0)
            $display("[lottery_weighted_pick_tree] OK");
        else
            $display("[lottery_weighted_pick_tree] ERROR");
        $finish;
    end

endmodule

>>> sim.f
src/lwpt_pkg.sv
src/lwpt_mod_div.sv
src/lottery_weighted_pick_tree.sv
src/lwpt_checker.sv
verif/tb.sv
